// ===== sv/spi_master_packet_sequencer_top_assert.svh =====
// assertion macros for the spi packet sequencer checker
// no dependencies; included by the checker file
`ifndef SPI_MASTER_PACKET_SEQUENCER_TOP_ASSERT_SVH
`define SPI_MASTER_PACKET_SEQUENCER_TOP_ASSERT_SVH

// antecedent holds in this cycle, consequent in the same cycle
`define SMPS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// antecedent holds in this cycle, consequent in the next cycle
`define SMPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/smps_pkg.sv =====
// shared types and codes for the spi master packet sequencer
// no dependencies
package smps_pkg;

   localparam int LENGTH_BITS_DEFAULT = 8;
   localparam logic [7:0] DUMMY_BYTE_RESET = 8'hff;

   localparam logic [1:0] MODE_SEND  = 2'd0;
   localparam logic [1:0] MODE_RECV  = 2'd1;
   localparam logic [1:0] MODE_XCHG  = 2'd2;
   localparam logic [1:0] MODE_EVENT = 2'd3;

   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_START_BUSY = 2'd1;
   localparam logic [1:0] STATUS_ZERO_LEN   = 2'd2;
   localparam logic [1:0] STATUS_EVENT_IDLE = 2'd3;

   typedef enum logic [3:0] {
      PHASE_IDLE = 4'b0001,
      PHASE_SEND = 4'b0010,
      PHASE_RECV = 4'b0100,
      PHASE_XCHG = 4'b1000
   } phase_type;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] length;
      logic [7:0] tx_byte;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic       send_valid;
      logic [7:0] send_byte;
      logic       store_valid;
      logic [7:0] store_byte;
      logic       select_active;
      logic       busy_res;
      logic       done_res;
      logic [1:0] status;
   } rsp_type;

endpackage

// ===== sv/spi_master_packet_sequencer_top.sv =====
// spi master packet sequencer: packet phase and byte count above a byte shifter
// depends on smps_pkg
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  smps_pkg::req_type
//   rsp      out        rsp_valid / rsp_stall  smps_pkg::rsp_type
//   csr      in         csr_write_en           8-bit dummy byte
//
// one item per cycle; each result appears in the cycle after its item is taken,
// set by the single result register after the phase and count decision.
// reset is synchronous: phase idle, count zero, dummy byte 0xff.
// a stalled result holds; a new item is still taken in the cycle the held
// result leaves, so only a stall on a full result register stalls the input.
module spi_master_packet_sequencer_top #(
   parameter int LENGTH_BITS = smps_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  smps_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output smps_pkg::rsp_type rsp_data,
   input  logic              csr_write_en,
   input  logic [7:0]        csr_write_data
);
   import smps_pkg::*;

   phase_type              phase_ff, phase_in;
   logic [LENGTH_BITS-1:0] remaining_ff, remaining_in;
   logic [7:0]             dummy_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   logic                   accept;
   logic [LENGTH_BITS+7:0] len_wide;
   logic [LENGTH_BITS-1:0] len_eff;
   logic [LENGTH_BITS-1:0] one_len;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // only the low LENGTH_BITS bits of the length count
   assign len_wide = {{LENGTH_BITS{1'b0}}, req_data.length};
   assign len_eff  = len_wide[LENGTH_BITS-1:0];
   assign one_len  = {{(LENGTH_BITS-1){1'b0}}, 1'b1};

   always_comb begin
      phase_type  next_phase;
      logic [7:0] out_byte;

      next_phase   = phase_ff;
      remaining_in = remaining_ff;
      rsp_in       = '0;
      out_byte     = req_data.tx_byte;

      if (req_data.mode != MODE_EVENT) begin
         if (phase_ff != PHASE_IDLE) begin
            rsp_in.status = STATUS_START_BUSY;
         end else if (len_eff == '0) begin
            rsp_in.status = STATUS_ZERO_LEN;
         end else begin
            case (req_data.mode)
               MODE_SEND: next_phase = PHASE_SEND;
               MODE_RECV: next_phase = PHASE_RECV;
               default:   next_phase = PHASE_XCHG;
            endcase
            remaining_in = len_eff - one_len;
            if (req_data.mode == MODE_RECV) begin
               out_byte = dummy_ff;
            end
            rsp_in.send_valid = 1'b1;
            rsp_in.send_byte  = out_byte;
         end
      end else begin
         if (phase_ff == PHASE_IDLE) begin
            rsp_in.status = STATUS_EVENT_IDLE;
         end else begin
            if (phase_ff != PHASE_SEND) begin
               rsp_in.store_valid = 1'b1;
               rsp_in.store_byte  = req_data.rx_byte;
            end
            if (remaining_ff != '0) begin
               remaining_in = remaining_ff - one_len;
               if (phase_ff == PHASE_RECV) begin
                  out_byte = dummy_ff;
               end
               rsp_in.send_valid = 1'b1;
               rsp_in.send_byte  = out_byte;
            end else begin
               next_phase      = PHASE_IDLE;
               rsp_in.done_res = 1'b1;
            end
         end
      end

      rsp_in.select_active = (next_phase != PHASE_IDLE);
      rsp_in.busy_res      = (next_phase != PHASE_IDLE);
      phase_in             = next_phase;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PHASE_IDLE;
         remaining_ff <= '0;
         dummy_ff     <= DUMMY_BYTE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            phase_ff     <= phase_in;
            remaining_ff <= remaining_in;
         end
         if (csr_write_en) begin
            dummy_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

// ===== sv/smps_checker.sv =====
// port-level checks for the spi master packet sequencer, bound to the top level
// depends on smps_pkg and spi_master_packet_sequencer_top_assert.svh
`include "spi_master_packet_sequencer_top_assert.svh"

module smps_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input smps_pkg::rsp_type rsp_data
);
   import smps_pkg::*;

   logic sent;
   logic closed;
   logic flagged;
   logic held_open;
   logic released;
   logic no_data;
   logic held_word;

   assign sent      = rsp_valid && rsp_data.send_valid;
   assign closed    = rsp_valid && rsp_data.done_res;
   assign flagged   = rsp_valid && (rsp_data.status != STATUS_OK);
   assign held_open = rsp_data.select_active && rsp_data.busy_res;
   assign released  = !rsp_data.select_active && !rsp_data.busy_res && !rsp_data.send_valid;
   assign no_data   = !rsp_data.send_valid && !rsp_data.store_valid && !rsp_data.done_res;
   assign held_word = rsp_valid && rsp_stall;

   // a byte handed out means the packet is still open
   `SMPS_ASSERT_SAME(a_send_keeps_select, clock, reset, sent, held_open, "send without select")

   // finishing a packet releases select
   `SMPS_ASSERT_SAME(a_done_releases, clock, reset, closed, released, "done with select held")

   // a flagged item moves no data
   `SMPS_ASSERT_SAME(a_status_no_data, clock, reset, flagged, no_data, "flagged item moved data")

   // a stalled result holds
   `SMPS_ASSERT_NEXT(a_stall_holds, clock, reset, held_word, rsp_valid && $stable(rsp_data), "stalled result changed")

endmodule

bind spi_master_packet_sequencer_top smps_checker u_smps_checker (.*);
